// ===== sv/ppps_pkg.sv =====
`timescale 1ns / 1ps
// ppps_pkg: shared types, widths, codes and reset values of the poll scheduler
// used by ppps_timer, priority_periodic_poll_scheduler and ppps_checker

package ppps_pkg;

    localparam int NOW_W         = 32;
    localparam int PERIOD_W      = 16;
    localparam int CODE_W        = 3;
    localparam int KIND_W        = 2;
    localparam int NUM_TIMERS    = 4;
    localparam int CFG_IDX_W     = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 8;

    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [CODE_W-1:0]   code_t;

    localparam kind_t KIND_DATA    = 2'd0;
    localparam kind_t KIND_RDS     = 2'd1;
    localparam kind_t KIND_QUALITY = 2'd2;
    localparam kind_t KIND_ALIVE   = 2'd3;

    localparam code_t EV_DATA_SYNC   = 3'd0;
    localparam code_t EV_AUTO_CHECK  = 3'd1;
    localparam code_t EV_RDS_ON      = 3'd2;
    localparam code_t EV_RDS_OFF     = 3'd3;
    localparam code_t EV_QUALITY_ON  = 3'd4;
    localparam code_t EV_QUALITY_OFF = 3'd5;
    localparam code_t EV_STOP_ALL    = 3'd6;
    localparam code_t EV_START_ALL   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_DATA_PERIOD    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RDS_PERIOD     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_PERIOD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALIVE_PERIOD   = 4'd3;

    localparam period_t DATA_PERIOD_RST    = 16'd400;
    localparam period_t RDS_PERIOD_RST     = 16'd150;
    localparam period_t QUALITY_PERIOD_RST = 16'd400;
    localparam period_t ALIVE_PERIOD_RST   = 16'd30000;

    // command bit in s_tuser
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic check;
        logic due;
    } tmr_ctrl_t;

endpackage

// ===== sv/ppps_timer.sv =====
`timescale 1ns / 1ps
// ppps_timer: one periodic timer with its last time stamp and recorded flag
// depends on ppps_pkg

module ppps_timer #(
    parameter int TIME_BITS = ppps_pkg::TIME_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [ppps_pkg::NOW_W-1:0] now_ms,
    input  ppps_pkg::period_t        period,
    input  logic                     check,
    output logic                     due
);
    import ppps_pkg::*;

    localparam int EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    logic [EXT_W-1:0]     now_ext;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] last_next;
    logic                 valid_reg;
    logic                 valid_next;

    assign now_ext = EXT_W'(now_ms);
    assign now_t   = now_ext[TIME_BITS-1:0];
    assign elapsed = now_t - last_reg;
    assign due     = valid_reg && (elapsed >= TIME_BITS'(period));

    // record on the first check and on every firing check
    always_comb begin
        valid_next = valid_reg;
        last_next  = last_reg;
        if (check) begin
            valid_next = 1'b1;
            if (!valid_reg || due) begin
                last_next = now_t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
    end

endmodule

// ===== sv/priority_periodic_poll_scheduler.sv =====
`timescale 1ns / 1ps
// priority_periodic_poll_scheduler: event/tick stream in, one poll result per item out
// depends on ppps_pkg and ppps_timer
//
// channel   dir  handshake               payload (lsb first)
// s_        in   s_tvalid / s_tready     tuser: cmd; tdata: event_code[2:0], now_ms[34:3]
// m_        out  m_tvalid / m_tready     tdata: fired[0], request_kind[2:1]
// cfg_      in   cfg_valid / cfg_ready   cfg_index, cfg_data (period in ms)
//
// one item per cycle while the result is not stalled by m_tready
// input register then result register; the priority chain over the four timers
// sits between them
// a stalled result holds the result register, the input register fills behind it
// reset is synchronous: flags, timers and periods return to their reset values

module priority_periodic_poll_scheduler #(
    parameter int TIME_BITS = ppps_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ppps_pkg::S_TDATA_W-1:0]    s_tdata,  // event_code, now_ms
    input  logic [ppps_pkg::S_TUSER_W-1:0]    s_tuser,  // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ppps_pkg::M_TDATA_W-1:0]    m_tdata,  // fired, request_kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  ppps_pkg::period_t                 cfg_data
);
    import ppps_pkg::*;

    logic              in_valid_reg;
    logic              in_cmd_reg;
    code_t             in_code_reg;
    logic [NOW_W-1:0]  in_now_reg;
    logic              advance;
    logic              s_acc;

    period_t           period_reg [NUM_TIMERS];

    logic              data_pend_reg, data_pend_next;
    logic              rds_en_reg,    rds_en_next;
    logic              qual_en_reg,   qual_en_next;
    logic              glob_en_reg,   glob_en_next;

    tmr_ctrl_t         tmr [NUM_TIMERS];
    logic              go;
    logic [NUM_TIMERS-1:0] fire;

    logic              out_valid_reg;
    logic              fired_reg, fired_next;
    kind_t             kind_reg,  kind_next;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_cmd_reg  <= s_tuser[0];
            in_code_reg <= s_tdata[CODE_W-1:0];
            in_now_reg  <= s_tdata[CODE_W+NOW_W-1:CODE_W];
        end
    end

    // period registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg[KIND_DATA]    <= DATA_PERIOD_RST;
            period_reg[KIND_RDS]     <= RDS_PERIOD_RST;
            period_reg[KIND_QUALITY] <= QUALITY_PERIOD_RST;
            period_reg[KIND_ALIVE]   <= ALIVE_PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DATA_PERIOD:    period_reg[KIND_DATA]    <= cfg_data;
                REG_RDS_PERIOD:     period_reg[KIND_RDS]     <= cfg_data;
                REG_QUALITY_PERIOD: period_reg[KIND_QUALITY] <= cfg_data;
                REG_ALIVE_PERIOD:   period_reg[KIND_ALIVE]   <= cfg_data;
                default: ;
            endcase
        end
    end

    // priority chain: a timer is checked only while every earlier one holds off
    assign go = in_valid_reg && advance && (in_cmd_reg == CMD_TICK) && glob_en_reg;

    assign tmr[KIND_DATA].check    = go && data_pend_reg;
    assign fire[KIND_DATA]         = tmr[KIND_DATA].check && tmr[KIND_DATA].due;
    assign tmr[KIND_RDS].check     = go && rds_en_reg && !fire[KIND_DATA];
    assign fire[KIND_RDS]          = tmr[KIND_RDS].check && tmr[KIND_RDS].due;
    assign tmr[KIND_QUALITY].check = go && qual_en_reg && !fire[KIND_DATA] && !fire[KIND_RDS];
    assign fire[KIND_QUALITY]      = tmr[KIND_QUALITY].check && tmr[KIND_QUALITY].due;
    assign tmr[KIND_ALIVE].check   = go && !fire[KIND_DATA] && !fire[KIND_RDS]
                                     && !fire[KIND_QUALITY];
    assign fire[KIND_ALIVE]        = tmr[KIND_ALIVE].check && tmr[KIND_ALIVE].due;

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_tmr
        ppps_timer #(
            .TIME_BITS (TIME_BITS)
        ) u_timer (
            .aclk    (aclk),
            .aresetn (aresetn),
            .now_ms  (in_now_reg),
            .period  (period_reg[k]),
            .check   (tmr[k].check),
            .due     (tmr[k].due)
        );
    end

    always_comb begin
        data_pend_next = data_pend_reg;
        rds_en_next    = rds_en_reg;
        qual_en_next   = qual_en_reg;
        glob_en_next   = glob_en_reg;
        fired_next     = |fire;
        kind_next      = KIND_DATA;
        if (fire[KIND_RDS]) begin
            kind_next = KIND_RDS;
        end else if (fire[KIND_QUALITY]) begin
            kind_next = KIND_QUALITY;
        end else if (fire[KIND_ALIVE]) begin
            kind_next = KIND_ALIVE;
        end
        if (fire[KIND_DATA]) begin
            data_pend_next = 1'b0;
        end
        if (in_valid_reg && advance && (in_cmd_reg == CMD_EVENT)) begin
            case (in_code_reg)
                EV_DATA_SYNC:   data_pend_next = 1'b1;
                EV_AUTO_CHECK:  data_pend_next = 1'b1;
                EV_RDS_ON:      rds_en_next    = 1'b1;
                EV_RDS_OFF:     rds_en_next    = 1'b0;
                EV_QUALITY_ON:  qual_en_next   = 1'b1;
                EV_QUALITY_OFF: qual_en_next   = 1'b0;
                EV_STOP_ALL:    glob_en_next   = 1'b0;
                EV_START_ALL:   glob_en_next   = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_pend_reg <= 1'b0;
            rds_en_reg    <= 1'b0;
            qual_en_reg   <= 1'b0;
            glob_en_reg   <= 1'b1;
        end else begin
            data_pend_reg <= data_pend_next;
            rds_en_reg    <= rds_en_next;
            qual_en_reg   <= qual_en_next;
            glob_en_reg   <= glob_en_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            fired_reg <= fired_next;
            kind_reg  <= kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({kind_reg, fired_reg});

endmodule

// ===== sv/ppps_checker.sv =====
`timescale 1ns / 1ps
// ppps_checker: port-level checks of the poll scheduler, bound to the top level
// depends on ppps_pkg and priority_periodic_poll_scheduler

module ppps_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [ppps_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ppps_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_ready
);
    import ppps_pkg::*;

    // no request kind without a firing
    a_kind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == KIND_DATA)
        else $error("request kind set on a result that did not fire");

    // an event transaction, with m_tready high while it sits in the input register, comes out as a non-firing result
    a_event_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_EVENT) ##1 m_tready
        |=> m_tvalid && !m_tdata[0])
        else $error("event transaction produced a firing result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind priority_periodic_poll_scheduler ppps_checker u_ppps_checker (.*);
